// ----- design/mpma_pkg.sv -----
package mpma_pkg;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_POW = 3'd4;
    localparam logic [2:0] CMD_NEG = 3'd5;
    localparam logic [2:0] CMD_EQU = 3'd6;

    localparam int CFG_COUNT = 4;

endpackage

// ----- design/mpma_modred.sv -----
// bit-serial modular reduction: x mod m, one bit of x per cycle
module mpma_modred #(
    parameter int W = 63
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] r
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  x_reg, x_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    dbl;

    always_comb begin
        r_next    = r_reg;
        x_next    = x_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dbl       = {r_reg, x_reg[W-1]};
        if (start) begin
            r_next    = '0;
            x_next    = x;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (dbl >= {1'b0, m}) begin
                dbl = dbl - {1'b0, m};
            end
            r_next   = dbl[W-1:0];
            x_next   = {x_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        r_reg <= r_next;
        x_reg <= x_next;
    end

    assign done = done_reg;
    assign r    = r_reg;
endmodule

// ----- design/mpma_mulmod.sv -----
// bit-serial shift-add modular multiplier, one bit of y per cycle
module mpma_mulmod #(
    parameter int W = 63
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] p
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  y_reg, y_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    s;

    always_comb begin
        r_next    = r_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        s         = {r_reg, 1'b0};
        if (start) begin
            r_next    = '0;
            y_next    = y;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (s >= {1'b0, m}) s = s - {1'b0, m};
            if (y_reg[W-1]) begin
                s = s + {1'b0, x};
                if (s >= {1'b0, m}) s = s - {1'b0, m};
            end
            r_next   = s[W-1:0];
            y_next   = {y_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        r_reg <= r_next;
        y_reg <= y_next;
    end

    assign done = done_reg;
    assign p    = r_reg;
endmodule

// ----- design/multi_prime_modular_alu_top.sv -----
// Modular ALU over LANES configurable moduli. One request in, one result out,
// one request at a time. Operands are first reduced modulo the lane modulus by
// a bit-serial reducer. Add, sub, negate and equal are then settled in the
// dispatch state; mul adds one pass of the bit-serial shift-add multiplier.
// Divide computes the Fermat inverse b^(m-2) by square-and-multiply over
// all RESIDUE_BITS exponent bits (two passes per bit) and then one more
// multiply; a zero divisor sets the zero-divide flag. Power with exponent two
// is a single squaring; otherwise power runs the same loop over the exponent,
// after an inverse loop when the exponent counts as negative. The worst case
// is a negative power. The multiplier is the single shared unit that sets the
// rate. The result is held in an output register; a new request is taken
// once it has been delivered and the sequencer is back in idle.
module multi_prime_modular_alu_top #(
    parameter int LANES        = 4,
    parameter int RESIDUE_BITS = 63
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [62:0]             cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [2:0]              s_command,
    input  logic [1:0]              s_lane,
    input  logic [RESIDUE_BITS-1:0] s_operand_a,
    input  logic [RESIDUE_BITS-1:0] s_operand_b,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [RESIDUE_BITS-1:0] m_value,
    output logic                    m_zero_divide,
    output logic                    m_equal_flag
);
    localparam int W  = RESIDUE_BITS;
    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int EW = $clog2(W + 1);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_REDA  = 4'd1;
    localparam logic [3:0] ST_REDB  = 4'd2;
    localparam logic [3:0] ST_DISP  = 4'd3;
    localparam logic [3:0] ST_PSQR  = 4'd4;  // square step of pow loop
    localparam logic [3:0] ST_PMUL  = 4'd5;  // multiply step of pow loop
    localparam logic [3:0] ST_PNEXT = 4'd6;
    localparam logic [3:0] ST_FMUL  = 4'd7;  // final single multiply
    localparam logic [3:0] ST_WAIT  = 4'd8;

    localparam logic [63:0] RST0 = 64'd9223372036854775783;
    localparam logic [63:0] RST1 = 64'd9223372036854775643;
    localparam logic [63:0] RST2 = 64'd9223372036854775549;
    localparam logic [63:0] RST3 = 64'd9223372036854775507;

    // modulus bank
    logic [W-1:0] mod_reg [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LANES; k++) begin
                case (k % mpma_pkg::CFG_COUNT)
                    0:       mod_reg[k] <= RST0[W-1:0];
                    1:       mod_reg[k] <= RST1[W-1:0];
                    2:       mod_reg[k] <= RST2[W-1:0];
                    default: mod_reg[k] <= RST3[W-1:0];
                endcase
            end
        end else if (cfg_we && (32'(cfg_index) < LANES)) begin
            mod_reg[LW'(cfg_index)] <= cfg_data[W-1:0];
        end
    end

    logic [3:0]   state_reg;
    logic [2:0]   cmd_reg;
    logic [W-1:0] m_reg, a_reg, b_reg;
    logic [W-1:0] base_reg, acc_reg, exp_reg;
    logic [EW-1:0] ecnt_reg;
    logic         inv_ph_reg;   // pow loop is computing an inverse
    logic         div_reg;      // after inverse, finish with a multiply
    logic         start_reg;    // one-cycle start for reducer or multiplier
    logic         out_v_reg;
    logic [W-1:0] val_reg;
    logic         zd_reg, eq_reg;

    // reducer
    logic         red_start, red_done;
    logic [W-1:0] red_x, red_r;
    // multiplier
    logic         mul_start, mul_done;
    logic [W-1:0] mul_x, mul_y, mul_p;

    mpma_modred #(.W(W)) u_red (
        .aclk(aclk), .aresetn(aresetn), .start(red_start), .x(red_x),
        .m(m_reg), .done(red_done), .r(red_r)
    );

    mpma_mulmod #(.W(W)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .x(mul_x), .y(mul_y),
        .m(m_reg), .done(mul_done), .p(mul_p)
    );

    logic accept;
    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_v_reg;
    assign m_value = val_reg;
    assign m_zero_divide = zd_reg;
    assign m_equal_flag  = eq_reg;

    // lane number folded into the bank; lane < 4 <= 2*LANES for LANES >= 2
    logic [LW-1:0] lane_sel;
    assign lane_sel = (LANES == 1) ? '0
                    : (32'(s_lane) >= LANES) ? LW'(32'(s_lane) - LANES)
                                             : LW'(s_lane);

    // 1 mod m, zero for the degenerate modulus one
    logic [W-1:0] one_mod;
    assign one_mod = (m_reg == W'(1)) ? '0 : W'(1);

    logic [W:0] sum_ab;
    assign sum_ab = {1'b0, a_reg} + {1'b0, b_reg};

    // command decode once both operands are reduced
    logic [W-1:0] dsp_val, dsp_acc, dsp_base, dsp_exp;
    logic         dsp_zd, dsp_eq, dsp_inv, dsp_div;
    logic [3:0]   dsp_state;

    always_comb begin
        dsp_val   = '0;
        dsp_zd    = 1'b0;
        dsp_eq    = 1'b0;
        dsp_acc   = one_mod;
        dsp_base  = b_reg;
        dsp_exp   = b_reg;
        dsp_inv   = 1'b0;
        dsp_div   = 1'b0;
        dsp_state = ST_WAIT;
        unique case (cmd_reg)
            mpma_pkg::CMD_ADD: begin
                dsp_val = (sum_ab >= {1'b0, m_reg})
                    ? W'(sum_ab - {1'b0, m_reg}) : sum_ab[W-1:0];
            end
            mpma_pkg::CMD_SUB: begin
                dsp_val = (b_reg > a_reg) ? (m_reg - b_reg) + a_reg : a_reg - b_reg;
            end
            mpma_pkg::CMD_NEG: dsp_val = (a_reg == '0) ? '0 : m_reg - a_reg;
            mpma_pkg::CMD_EQU: dsp_eq = (a_reg == b_reg);
            mpma_pkg::CMD_MUL: begin
                dsp_acc   = a_reg;
                dsp_state = ST_FMUL;
            end
            mpma_pkg::CMD_DIV: begin
                if (b_reg == '0) begin
                    dsp_zd = 1'b1;
                end else begin
                    // inverse of b, then times a
                    dsp_exp   = m_reg - W'(2);
                    dsp_div   = 1'b1;
                    dsp_state = ST_PMUL;
                end
            end
            mpma_pkg::CMD_POW: begin
                if (b_reg == W'(2)) begin
                    // plain square
                    dsp_acc   = a_reg;
                    dsp_base  = a_reg;
                    dsp_state = ST_FMUL;
                end else if (b_reg < (m_reg >> 1)) begin
                    dsp_base  = a_reg;
                    dsp_state = ST_PMUL;
                end else if (a_reg == '0) begin
                    dsp_zd = 1'b1;
                end else begin
                    // negative exponent: invert the base first
                    dsp_base  = a_reg;
                    dsp_exp   = m_reg - W'(2);
                    dsp_inv   = 1'b1;
                    dsp_state = ST_PMUL;
                end
            end
            default: ;
        endcase
    end

    // operand routing for reducer and multiplier
    always_comb begin
        red_start = 1'b0;
        red_x     = a_reg;
        mul_start = 1'b0;
        mul_x     = base_reg;
        mul_y     = acc_reg;
        unique case (state_reg) inside
            ST_REDA: red_start = start_reg;
            ST_REDB: begin
                red_start = start_reg;
                red_x     = b_reg;
            end
            ST_PMUL, ST_FMUL: mul_start = start_reg;
            ST_PSQR: begin
                mul_start = start_reg;
                mul_y     = base_reg;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            out_v_reg  <= 1'b0;
            start_reg  <= 1'b0;
            inv_ph_reg <= 1'b0;
            div_reg    <= 1'b0;
            val_reg    <= '0;
            zd_reg     <= 1'b0;
            eq_reg     <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cmd_reg   <= s_command;
                        m_reg     <= (mod_reg[lane_sel] == '0) ? W'(1)
                                                                : mod_reg[lane_sel];
                        a_reg     <= s_operand_a;
                        b_reg     <= s_operand_b;
                        start_reg <= 1'b1;
                        state_reg <= ST_REDA;
                    end
                end
                ST_REDA: begin
                    if (start_reg) begin
                        start_reg <= 1'b0;
                    end else if (red_done) begin
                        a_reg     <= red_r;
                        start_reg <= 1'b1;
                        state_reg <= ST_REDB;
                    end
                end
                ST_REDB: begin
                    if (start_reg) begin
                        start_reg <= 1'b0;
                    end else if (red_done) begin
                        b_reg     <= red_r;
                        state_reg <= ST_DISP;
                    end
                end
                ST_DISP: begin
                    val_reg    <= dsp_val;
                    zd_reg     <= dsp_zd;
                    eq_reg     <= dsp_eq;
                    acc_reg    <= dsp_acc;
                    base_reg   <= dsp_base;
                    exp_reg    <= dsp_exp;
                    ecnt_reg   <= EW'(W);
                    inv_ph_reg <= dsp_inv;
                    div_reg    <= dsp_div;
                    out_v_reg  <= (dsp_state == ST_WAIT);
                    start_reg  <= (dsp_state != ST_WAIT);
                    state_reg  <= dsp_state;
                end
                ST_PMUL: begin
                    if (start_reg) begin
                        start_reg <= 1'b0;
                    end else if (mul_done) begin
                        if (exp_reg[0]) acc_reg <= mul_p;
                        start_reg <= 1'b1;
                        state_reg <= ST_PSQR;
                    end
                end
                ST_PSQR: begin
                    if (start_reg) begin
                        start_reg <= 1'b0;
                    end else if (mul_done) begin
                        base_reg <= mul_p;
                        exp_reg  <= exp_reg >> 1;
                        ecnt_reg <= ecnt_reg - EW'(1);
                        if (ecnt_reg == EW'(1)) begin
                            state_reg <= ST_PNEXT;
                        end else begin
                            start_reg <= 1'b1;
                            state_reg <= ST_PMUL;
                        end
                    end
                end
                ST_PNEXT: begin
                    if (inv_ph_reg) begin
                        // inverse done: raise it to m - b
                        inv_ph_reg <= 1'b0;
                        base_reg   <= acc_reg;
                        acc_reg    <= one_mod;
                        exp_reg    <= m_reg - b_reg;
                        ecnt_reg   <= EW'(W);
                        start_reg  <= 1'b1;
                        state_reg  <= ST_PMUL;
                    end else if (div_reg) begin
                        base_reg   <= acc_reg;
                        acc_reg    <= a_reg;
                        start_reg  <= 1'b1;
                        state_reg  <= ST_FMUL;
                    end else begin
                        val_reg    <= acc_reg;
                        out_v_reg  <= 1'b1;
                        state_reg  <= ST_WAIT;
                    end
                end
                ST_FMUL: begin
                    if (start_reg) begin
                        start_reg <= 1'b0;
                    end else if (mul_done) begin
                        val_reg   <= mul_p;
                        out_v_reg <= 1'b1;
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (m_ready) begin
                        out_v_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- design/mpma_checker.sv -----
module mpma_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_zero_divide,
    input logic m_equal_flag
);
    // no new request while a result is pending
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("request taken with result pending");

    // flags are exclusive
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_zero_divide && m_equal_flag)) else $error("both flags set");

    // result held until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");

    // a result never follows an accept in the very next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid) else $error("result too early");
endmodule

bind multi_prime_modular_alu_top mpma_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_zero_divide(m_zero_divide),
    .m_equal_flag(m_equal_flag)
);

// ----- test/mpma_result_checker.sv -----
`timescale 1ns / 100ps

module mpma_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [62:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [1:0]  s_lane,
    input  logic [62:0] s_operand_a,
    input  logic [62:0] s_operand_b,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [62:0] m_value,
    input  logic        m_zero_divide,
    input  logic        m_equal_flag,
    output int          fail_count,
    output int          results_owed
);

    typedef struct packed {
        logic [62:0] value;
        logic        zero_divide;
        logic        equal_flag;
    } residue_result_t;

    localparam logic [62:0] RESET_PRIMES [4] = '{
        63'd9223372036854775783, 63'd9223372036854775643,
        63'd9223372036854775549, 63'd9223372036854775507
    };

    logic [62:0]     lane_prime [4];
    residue_result_t owed_results [$];
    int              mismatches;

    function automatic logic [63:0] add_residue(logic [63:0] x, logic [63:0] y,
                                                logic [63:0] m);
        logic [63:0] s;
        s = x + y;
        if (s >= m) s = s - m;
        return s;
    endfunction

    // shift-add product, msb of y first
    function automatic logic [63:0] mul_residue(logic [63:0] x, logic [63:0] y,
                                                logic [63:0] m);
        logic [63:0] r;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = add_residue(r, r, m);
            if (y[i]) r = add_residue(r, x, m);
        end
        return r;
    endfunction

    function automatic logic [63:0] pow_residue(logic [63:0] base, logic [63:0] ex,
                                                logic [63:0] m);
        logic [63:0] r;
        r = 64'd1 % m;
        while (ex != 0) begin
            if (ex[0]) r = mul_residue(r, base, m);
            base = mul_residue(base, base, m);
            ex = ex >> 1;
        end
        return r;
    endfunction

    // fermat inverse
    function automatic logic [63:0] inv_residue(logic [63:0] x, logic [63:0] m);
        if (m < 2) return 0;
        return pow_residue(x, m - 2, m);
    endfunction

    function automatic residue_result_t modular_result(logic [2:0] cmd, logic [1:0] lane,
                                                       logic [62:0] op_a, logic [62:0] op_b);
        residue_result_t res;
        logic [63:0] m;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] v;
        res = '0;
        v = 0;
        m = {1'b0, lane_prime[lane]};
        if (m < 1) m = 1;
        a = {1'b0, op_a} % m;
        b = {1'b0, op_b} % m;
        case (cmd)
            mpma_pkg::CMD_ADD: v = add_residue(a, b, m);
            mpma_pkg::CMD_SUB: v = (b > a) ? (m - b) + a : a - b;
            mpma_pkg::CMD_MUL: v = mul_residue(a, b, m);
            mpma_pkg::CMD_DIV: begin
                if (b == 0) res.zero_divide = 1'b1;
                else v = mul_residue(a, inv_residue(b, m), m);
            end
            mpma_pkg::CMD_POW: begin
                if (b == 2) v = mul_residue(a, a, m);
                else if (b < (m >> 1)) v = pow_residue(a, b, m);
                else if (a == 0) res.zero_divide = 1'b1;
                else v = pow_residue(inv_residue(a, m), m - b, m);
            end
            mpma_pkg::CMD_NEG: v = (a == 0) ? 64'd0 : m - a;
            mpma_pkg::CMD_EQU: res.equal_flag = (a == b);
            default: ;
        endcase
        res.value = v[62:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        residue_result_t want;
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) lane_prime[k] = RESET_PRIMES[k];
            owed_results.delete();
            fail_count = 0;
            mismatches = 0;
        end else begin
            if (cfg_we) lane_prime[cfg_index] = cfg_data;
            if (s_valid && s_ready)
                owed_results = {owed_results, modular_result(s_command, s_lane,
                                                             s_operand_a, s_operand_b)};
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    fail_count++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value %0d zd %0b eq %0b",
                                 m_value, m_zero_divide, m_equal_flag);
                end else begin
                    want = owed_results.pop_front();
                    if (want.value !== m_value || want.zero_divide !== m_zero_divide ||
                        want.equal_flag !== m_equal_flag) begin
                        fail_count++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected value %0d zd %0b eq %0b,",
                                      " got value %0d zd %0b eq %0b"},
                                     want.value, want.zero_divide, want.equal_flag,
                                     m_value, m_zero_divide, m_equal_flag);
                    end
                end
            end
        end
        results_owed = owed_results.size();
    end

endmodule

// ----- test/multi_prime_modular_alu_top_test.sv -----
`timescale 1ns / 100ps

module multi_prime_modular_alu_top_test;

    // command code with no operation behind it
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    // configuration register indexes
    localparam logic [1:0] REG_PRIME_LANE0 = 2'd0;
    localparam logic [1:0] REG_PRIME_LANE1 = 2'd1;
    localparam logic [1:0] REG_PRIME_LANE2 = 2'd2;
    localparam logic [1:0] REG_PRIME_LANE3 = 2'd3;

    localparam logic [62:0] ALL_ONES = {63{1'b1}};
    localparam int CYCLE_LIMIT = 10_000_000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [62:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_command;
    logic [1:0]  s_lane;
    logic [62:0] s_operand_a;
    logic [62:0] s_operand_b;
    logic        m_valid;
    logic        m_ready;
    logic [62:0] m_value;
    logic        m_zero_divide;
    logic        m_equal_flag;

    int          fail_count;
    int          results_owed;
    int          cycle_count;
    int          hold_len;      // long receiver hold-off, picked up by the receiver
    bit          no_idle;       // quiet tail of the run: no bursts on either side
    logic [62:0] moduli [4];    // stimulus copy of the moduli, for shaping operands

    multi_prime_modular_alu_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_lane        (s_lane),
        .s_operand_a   (s_operand_a),
        .s_operand_b   (s_operand_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_zero_divide (m_zero_divide),
        .m_equal_flag  (m_equal_flag)
    );

    mpma_result_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_lane        (s_lane),
        .s_operand_a   (s_operand_a),
        .s_operand_b   (s_operand_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_zero_divide (m_zero_divide),
        .m_equal_flag  (m_equal_flag),
        .fail_count    (fail_count),
        .results_owed  (results_owed)
    );

    // 10 ns clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[multi_prime_modular_alu_top] ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_len != 0 && !hold_done) begin
                m_ready = 1'b0;
                repeat (hold_len - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    function automatic logic [62:0] rand_wide();
        return 63'({$urandom, $urandom});
    endfunction

    // operand shaped around the lane modulus: mostly in range, some wide
    function automatic logic [62:0] pick_operand(logic [62:0] m);
        case ($urandom_range(0, 5))
            0:       return rand_wide();
            1:       return 63'($urandom_range(0, 20));
            2:       return (m > 21) ? m - 1 - 63'($urandom_range(0, 20)) : 63'd0;
            3:       return (m > 21) ? (m >> 1) - 10 + 63'($urandom_range(0, 20)) : 63'd2;
            default: return (m > 1) ? rand_wide() % m : rand_wide();
        endcase
    endfunction

    task automatic write_prime(logic [1:0] idx, logic [62:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        moduli[idx] = value;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic write_all_primes(logic [62:0] p0, logic [62:0] p1,
                                    logic [62:0] p2, logic [62:0] p3);
        write_prime(REG_PRIME_LANE0, p0);
        write_prime(REG_PRIME_LANE1, p1);
        write_prime(REG_PRIME_LANE2, p2);
        write_prime(REG_PRIME_LANE3, p3);
    endtask

    // offer one request and hold it until taken
    task automatic send_request(logic [2:0] cmd, logic [1:0] lane,
                                logic [62:0] op_a, logic [62:0] op_b);
        @(negedge aclk);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_command   = cmd;
        s_lane      = lane;
        s_operand_a = op_a;
        s_operand_b = op_b;
        #1;
        while (!s_ready) begin
            @(negedge aclk);
            #1;
        end
        @(posedge aclk);
    endtask

    task automatic send_random(int count, int quiet_from);
        logic [1:0] lane;
        for (int n = 0; n < count; n++) begin
            if (n >= quiet_from) no_idle = 1'b1;
            lane = 2'($urandom_range(0, 3));
            send_request(3'($urandom_range(0, 7)), lane,
                         pick_operand(moduli[lane]), pick_operand(moduli[lane]));
        end
    endtask

    // pause the request side until every result is back
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (results_owed != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    initial begin
        logic [62:0] m0;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_command   = mpma_pkg::CMD_ADD;
        s_lane      = '0;
        s_operand_a = '0;
        s_operand_b = '0;
        hold_len    = 0;
        no_idle     = 1'b0;
        moduli[0] = 63'd9223372036854775783;
        moduli[1] = 63'd9223372036854775643;
        moduli[2] = 63'd9223372036854775549;
        moduli[3] = 63'd9223372036854775507;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed, reset moduli
        m0 = moduli[0];
        send_request(mpma_pkg::CMD_ADD, 2'd0, m0 - 1, m0 - 1);
        send_request(mpma_pkg::CMD_SUB, 2'd1, 63'd3, 63'd10);
        send_request(mpma_pkg::CMD_SUB, 2'd2, 63'd10, 63'd3);
        send_request(mpma_pkg::CMD_MUL, 2'd3, m0 - 1, m0 - 2);
        send_request(mpma_pkg::CMD_DIV, 2'd0, 63'd12345, 63'd0);
        send_request(mpma_pkg::CMD_DIV, 2'd1, 63'd12345, 63'd67890);
        send_request(mpma_pkg::CMD_POW, 2'd2, 63'd987654321, 63'd2);
        send_request(mpma_pkg::CMD_POW, 2'd3, 63'd0, 63'd0);
        send_request(mpma_pkg::CMD_POW, 2'd0, 63'd0, m0 - 5);
        send_request(mpma_pkg::CMD_POW, 2'd0, 63'd77, m0 - 5);
        send_request(mpma_pkg::CMD_POW, 2'd0, 63'd77, (m0 >> 1) - 1);
        send_request(mpma_pkg::CMD_POW, 2'd0, 63'd77, m0 >> 1);
        send_request(mpma_pkg::CMD_NEG, 2'd1, 63'd0, ALL_ONES);
        send_request(mpma_pkg::CMD_NEG, 2'd1, 63'd5, 63'd0);
        send_request(mpma_pkg::CMD_EQU, 2'd2, 63'd42, 63'd42);
        send_request(mpma_pkg::CMD_EQU, 2'd2, 63'd42, 63'd43);
        // first operand not below the modulus, both reduced before compare
        send_request(mpma_pkg::CMD_EQU, 2'd0, ALL_ONES, ALL_ONES - m0);
        send_request(mpma_pkg::CMD_ADD, 2'd3, ALL_ONES, ALL_ONES);
        send_request(CMD_UNUSED, 2'd1, 63'd9, 63'd9);

        // long result stall while requests keep coming; longer than the
        // slowest request so a finished result waits and blocks the input
        hold_len = 40000;
        send_random(30, 1000);
        drain();

        // extreme moduli: smallest odd prime, all ones, zero and one
        write_all_primes(63'd3, ALL_ONES, 63'd0, 63'd1);
        send_request(mpma_pkg::CMD_DIV, 2'd2, 63'd5, 63'd7);
        send_request(mpma_pkg::CMD_POW, 2'd3, 63'd5, 63'd7);
        send_request(mpma_pkg::CMD_EQU, 2'd3, 63'd5, 63'd7);
        send_random(20, 1000);
        drain();

        // small primes
        write_all_primes(63'd7, 63'd13, 63'd251, 63'd65521);
        send_random(20, 1000);
        drain();

        // random moduli, quiet tail at the end
        write_all_primes(rand_wide(), rand_wide(), 63'd9223372036854775783, rand_wide());
        send_random(24, 12);
        drain();

        repeat (50) @(posedge aclk);
        if (fail_count == 0 && results_owed == 0) begin
            $display("[multi_prime_modular_alu_top] OK");
        end else begin
            $display("[multi_prime_modular_alu_top] ERROR");
        end
        $finish;
    end

endmodule
